@@ rtl/htr_pkg.sv @@
package htr_pkg;

   typedef logic [1:0] slot_type;

   localparam slot_type SLOT_REF     = 2'd0;
   localparam slot_type SLOT_INSIDE  = 2'd1;
   localparam slot_type SLOT_OUTSIDE = 2'd2;

   // configuration register indexes
   localparam int CSR_COUNT = 8;
   localparam int CSR_IDX_W = 3;
   localparam logic [CSR_IDX_W-1:0] CSR_SUMMER_ON    = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SUMMER_OFF   = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_NORMAL_ON    = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_NORMAL_OFF   = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_SUMMER_ENTER = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_SUMMER_EXIT  = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_START_DELAY  = 3'd6;
   localparam logic [CSR_IDX_W-1:0] CSR_MIN_ON_TIME  = 3'd7;

   localparam logic [15:0] CSR_RESET [CSR_COUNT] = '{
      16'd80, 16'd50, 16'd60, 16'd30, 16'd250, 16'd240, 16'd1, 16'd5
   };

   // conversion constants
   localparam logic [15:0] INSIDE_BIAS    = 16'd13653;
   localparam logic [15:0] OUTSIDE_BIAS   = 16'd39361;
   localparam logic [15:0] INSIDE_OFFSET  = 16'd240;
   localparam logic [15:0] OUTSIDE_OFFSET = 16'd5;

   // x/55 and x/29 as (x * recip) >> 22, exact for x < 2^16 (x/55) and x < 2^17 (x/29)
   localparam int          MUL_X_W     = 17;
   localparam int          MUL_M_W     = 18;
   localparam int          MUL_P_W     = MUL_X_W + MUL_M_W;
   localparam int          RECIP_SHIFT = 22;
   localparam logic [MUL_M_W-1:0] RECIP_55 = 18'd76261;
   localparam logic [MUL_M_W-1:0] RECIP_29 = 18'd144632;
   localparam int          QUOT_W      = 12;

   typedef struct packed {
      slot_type    slot;
      logic [15:0] raw;
      logic [15:0] minute;
      logic        select_press;
      logic        next_press;
   } a_word_type;

   typedef struct packed {
      slot_type          slot;
      logic [QUOT_W-1:0] quot;
      logic              neg;
      logic [15:0]       minute;
      logic              select_press;
      logic              next_press;
   } b_word_type;

   typedef struct packed {
      slot_type    slot;
      logic [15:0] value;
      logic [15:0] minute;
      logic        select_press;
      logic        next_press;
   } c_word_type;

   typedef struct packed {
      logic        relay_on;
      logic        summer_mode;
      logic        info_mode;
      logic [15:0] inside_temp;
      logic [15:0] outside_temp;
      logic [15:0] latest_interval;
      logic [15:0] earlier_interval;
      slot_type    channel_slot;
   } rsp_word_type;

   function automatic slot_type next_slot(input slot_type cur);
      slot_type nxt;
      unique case (cur)
         SLOT_REF:     nxt = SLOT_INSIDE;
         SLOT_INSIDE:  nxt = SLOT_OUTSIDE;
         SLOT_OUTSIDE: nxt = SLOT_REF;
         default:      nxt = SLOT_REF;
      endcase
      return nxt;
   endfunction

endpackage

@@ rtl/htr_if.sv @@
interface htr_req_if;
   logic        valid;
   logic        ready;
   logic [15:0] raw_sample;
   logic [15:0] minute_count;
   logic        select_press;
   logic        next_press;

   modport source (output valid, raw_sample, minute_count, select_press, next_press,
                   input ready);
   modport sink   (input valid, raw_sample, minute_count, select_press, next_press,
                   output ready);
endinterface

interface htr_rsp_if;
   logic               valid;
   logic               ready;
   logic               relay_on;
   logic               summer_mode;
   logic               info_mode;
   logic signed [15:0] inside_temp;
   logic signed [15:0] outside_temp;
   logic        [15:0] latest_interval;
   logic        [15:0] earlier_interval;
   logic        [1:0]  channel_slot;

   modport source (output valid, relay_on, summer_mode, info_mode, inside_temp,
                   outside_temp, latest_interval, earlier_interval, channel_slot,
                   input ready);
   modport sink   (input valid, relay_on, summer_mode, info_mode, inside_temp,
                   outside_temp, latest_interval, earlier_interval, channel_slot,
                   output ready);
endinterface

@@ rtl/hysteresis_thermostat_relay.sv @@
// Thermostat relay controller. Each req word is one converter sample; a fixed
// rotation labels it reference, inside or outside reading, and every word yields
// one rsp word with relay, mode flags, both temperatures, the last two switch
// intervals and the slot of the next sample. One word is taken per cycle unless
// the output stalls; a word runs through four register stages (input,
// reciprocal multiply, temperature value, relay state and output) in that
// order before its rsp word is valid. The single 17x18 multiplier that does
// the divisions by 55 and 29 sets the stage depth. csr writes must go only
// between words, when the pipeline is empty; the block does not enforce it.
module hysteresis_thermostat_relay import htr_pkg::*; #(
   parameter int HISTORY_DEPTH = 3
) (
   input  logic                 clock,
   input  logic                 reset,
   htr_req_if.sink              req_bus,
   htr_rsp_if.source            rsp_bus,
   input  logic                 csr_write_en,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [15:0]          csr_data
);

   localparam int LAST = HISTORY_DEPTH - 1;

   logic [15:0]  csr_ff [CSR_COUNT];

   slot_type     slot_ff;
   logic         a_valid_ff, b_valid_ff, c_valid_ff, rsp_valid_ff;
   a_word_type   a_ff;
   b_word_type   b_ff;
   c_word_type   c_ff;
   rsp_word_type rsp_ff, rsp_in;

   logic [15:0]  ref_ff;
   logic [15:0]  inside_ff, inside_in;
   logic [15:0]  outside_ff, outside_in;
   logic         relay_ff, relay_in;
   logic         summer_ff, summer_in;
   logic         info_ff, info_in;
   logic [15:0]  hist_ff [HISTORY_DEPTH];
   logic [15:0]  hist_in [HISTORY_DEPTH];

   logic out_free, c_free, b_free, a_free;
   logic c_move, b_move, a_move, accept;

   // ---------------- flow control ----------------
   assign out_free = !rsp_valid_ff || rsp_bus.ready;
   assign c_free   = !c_valid_ff || out_free;
   assign b_free   = !b_valid_ff || c_free;
   assign a_free   = !a_valid_ff || b_free;
   assign c_move   = c_valid_ff && out_free;
   assign b_move   = b_valid_ff && c_free;
   assign a_move   = a_valid_ff && b_free;
   assign accept   = req_bus.valid && a_free;

   assign req_bus.ready = a_free;

   // ---------------- configuration ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         csr_ff <= CSR_RESET;
      end else if (csr_write_en) begin
         csr_ff[csr_index] <= csr_data;
      end
   end

   // ---------------- input stage ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         slot_ff    <= SLOT_REF;
         a_valid_ff <= 1'b0;
      end else begin
         if (accept) begin
            slot_ff <= next_slot(slot_ff);
         end
         if (a_free) begin
            a_valid_ff <= accept;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         a_ff.slot         <= slot_ff;
         a_ff.raw          <= req_bus.raw_sample;
         a_ff.minute       <= req_bus.minute_count;
         a_ff.select_press <= req_bus.select_press;
         a_ff.next_press   <= req_bus.next_press;
      end
   end

   // ---------------- reciprocal multiply ----------------
   logic [15:0]        inside_diff;
   logic [15:0]        outside_diff;
   logic [15:0]        outside_mag;
   logic [MUL_X_W-1:0] mul_x;
   logic [MUL_M_W-1:0] mul_m;
   logic [MUL_P_W-1:0] mul_p;

   always_comb begin
      inside_diff  = a_ff.raw - INSIDE_BIAS;
      outside_diff = a_ff.raw - OUTSIDE_BIAS;
      // 0x8000 maps to 32768, which still fits as unsigned
      outside_mag  = outside_diff[15] ? 16'(16'd0 - outside_diff) : outside_diff;
      if (a_ff.slot == SLOT_INSIDE) begin
         mul_x = {1'b0, inside_diff};
         mul_m = RECIP_55;
      end else begin
         mul_x = {outside_mag, 1'b0};
         mul_m = RECIP_29;
      end
      mul_p = mul_x * mul_m;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff <= 1'b0;
         ref_ff     <= '0;
      end else begin
         if (b_free) begin
            b_valid_ff <= a_move;
         end
         // later inside words are still in order behind this one
         if (a_move && a_ff.slot == SLOT_REF) begin
            ref_ff <= a_ff.raw;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (a_move) begin
         b_ff.slot         <= a_ff.slot;
         b_ff.quot         <= mul_p[RECIP_SHIFT +: QUOT_W];
         b_ff.neg          <= outside_diff[15];
         b_ff.minute       <= a_ff.minute;
         b_ff.select_press <= a_ff.select_press;
         b_ff.next_press   <= a_ff.next_press;
      end
   end

   // ---------------- temperature value ----------------
   logic [15:0] quot_ext;
   logic [15:0] value_c;

   always_comb begin
      quot_ext = {{(16 - QUOT_W){1'b0}}, b_ff.quot};
      unique case (b_ff.slot)
         SLOT_INSIDE:  value_c = quot_ext - ref_ff - INSIDE_OFFSET;
         SLOT_OUTSIDE: value_c = (b_ff.neg ? 16'(16'd0 - quot_ext) : quot_ext)
                                 - OUTSIDE_OFFSET;
         default:      value_c = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         c_valid_ff <= 1'b0;
      end else if (c_free) begin
         c_valid_ff <= b_move;
      end
   end

   always_ff @(posedge clock) begin
      if (b_move) begin
         c_ff.slot         <= b_ff.slot;
         c_ff.value        <= value_c;
         c_ff.minute       <= b_ff.minute;
         c_ff.select_press <= b_ff.select_press;
         c_ff.next_press   <= b_ff.next_press;
      end
   end

   // ---------------- relay state ----------------
   logic        [15:0] on_lvl, off_lvl;
   logic        [15:0] elapsed;
   logic               turn_on, turn_off;

   always_comb begin
      inside_in  = (c_ff.slot == SLOT_INSIDE)  ? c_ff.value : inside_ff;
      outside_in = (c_ff.slot == SLOT_OUTSIDE) ? c_ff.value : outside_ff;
      info_in    = info_ff ^ c_ff.select_press;

      summer_in  = summer_ff ^ c_ff.next_press;
      if ($signed(outside_in) > $signed(csr_ff[CSR_SUMMER_ENTER])) begin
         summer_in = 1'b1;
      end
      if ($signed(outside_in) < $signed(csr_ff[CSR_SUMMER_EXIT]) && relay_ff) begin
         summer_in = 1'b0;
      end

      on_lvl  = summer_in ? csr_ff[CSR_SUMMER_ON]  : csr_ff[CSR_NORMAL_ON];
      off_lvl = summer_in ? csr_ff[CSR_SUMMER_OFF] : csr_ff[CSR_NORMAL_OFF];
      elapsed = c_ff.minute - hist_ff[LAST];

      turn_on  = !relay_ff && ($signed(inside_in) > $signed(on_lvl))
                 && (c_ff.minute > csr_ff[CSR_START_DELAY]);
      // a fresh turn-on leaves zero elapsed time, so the off check cannot pass
      turn_off = relay_ff && ($signed(inside_in) < $signed(off_lvl))
                 && (elapsed > csr_ff[CSR_MIN_ON_TIME]);
      relay_in = relay_ff ^ (turn_on || turn_off);

      for (int i = 0; i < HISTORY_DEPTH; i++) begin
         hist_in[i] = hist_ff[i];
      end
      if (turn_on || turn_off) begin
         for (int i = 0; i < HISTORY_DEPTH - 1; i++) begin
            hist_in[i] = hist_ff[i + 1];
         end
         hist_in[LAST] = c_ff.minute;
      end

      rsp_in.relay_on         = relay_in;
      rsp_in.summer_mode      = summer_in;
      rsp_in.info_mode        = info_in;
      rsp_in.inside_temp      = inside_in;
      rsp_in.outside_temp     = outside_in;
      rsp_in.latest_interval  = hist_in[LAST] - hist_in[LAST - 1];
      rsp_in.earlier_interval = hist_in[LAST - 1] - hist_in[LAST - 2];
      rsp_in.channel_slot     = next_slot(c_ff.slot);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         inside_ff    <= '0;
         outside_ff   <= '0;
         relay_ff     <= 1'b0;
         summer_ff    <= 1'b0;
         info_ff      <= 1'b0;
         for (int i = 0; i < HISTORY_DEPTH; i++) begin
            hist_ff[i] <= '0;
         end
      end else begin
         if (out_free) begin
            rsp_valid_ff <= c_move;
         end
         if (c_move) begin
            inside_ff  <= inside_in;
            outside_ff <= outside_in;
            relay_ff   <= relay_in;
            summer_ff  <= summer_in;
            info_ff    <= info_in;
            hist_ff    <= hist_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (c_move) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_bus.valid            = rsp_valid_ff;
   assign rsp_bus.relay_on         = rsp_ff.relay_on;
   assign rsp_bus.summer_mode      = rsp_ff.summer_mode;
   assign rsp_bus.info_mode        = rsp_ff.info_mode;
   assign rsp_bus.inside_temp      = rsp_ff.inside_temp;
   assign rsp_bus.outside_temp     = rsp_ff.outside_temp;
   assign rsp_bus.latest_interval  = rsp_ff.latest_interval;
   assign rsp_bus.earlier_interval = rsp_ff.earlier_interval;
   assign rsp_bus.channel_slot     = rsp_ff.channel_slot;

`ifndef SYNTH
   // every relay switch logs its minute as the newest history entry
   a_switch_logged: assert property (@(posedge clock) disable iff (reset)
      (c_move && (relay_in != relay_ff)) |=> (hist_ff[LAST] == $past(c_ff.minute)))
      else $error("relay switch not logged in history");

   // relay turns on only after the start delay
   a_start_delay: assert property (@(posedge clock) disable iff (reset)
      (c_move && !relay_ff && relay_in) |-> (c_ff.minute > csr_ff[CSR_START_DELAY]))
      else $error("relay turned on before start delay");

   // relay turns off only after the minimum on time since the last switch
   a_min_on: assert property (@(posedge clock) disable iff (reset)
      (c_move && relay_ff && !relay_in)
         |-> (16'(c_ff.minute - hist_ff[LAST]) > csr_ff[CSR_MIN_ON_TIME]))
      else $error("relay turned off before minimum on time");

   // a stalled value word holds until the output frees up
   a_c_hold: assert property (@(posedge clock) disable iff (reset)
      (c_valid_ff && !out_free) |=> (c_valid_ff && $stable(c_ff)))
      else $error("value stage word lost under stall");

   // the slot rotation never reaches the unused code
   a_slot_range: assert property (@(posedge clock) disable iff (reset)
      accept |=> (slot_ff == SLOT_REF || slot_ff == SLOT_INSIDE
                  || slot_ff == SLOT_OUTSIDE))
      else $error("slot counter out of rotation");
`endif

endmodule
